/* hw/rtl/nsch_pkg.sv */
// Package for the nearest segment/circle hit block.
// Holds sizes, the queued item type and the sequencer state type.
// No dependencies.
`default_nettype none
package nsch_pkg;

	localparam int MAX_TARGETS = 256;
	localparam int SLOT_W      = $clog2(MAX_TARGETS);
	localparam int CNT_W       = $clog2(MAX_TARGETS + 1);
	localparam int IDX_W       = 9;
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

	localparam int LEN_W  = 50;
	localparam int DIV_Q_W = 16;

	localparam logic [LEN_W-1:0] SEG_THRESHOLD = LEN_W'(65);
	localparam logic [16:0]      T_ONE         = 17'h10000;
	localparam logic [53:0]      D_MAX         = 54'h4_0000_0000;

	typedef struct packed {
		logic [23:0]       prev_x;
		logic [23:0]       prev_y;
		logic [23:0]       cur_x;
		logic [23:0]       cur_y;
		logic [15:0]       base_radius;
		logic [23:0]       target_x;
		logic [23:0]       target_y;
		logic [15:0]       target_radius;
		logic              active;
		logic [SLOT_W-1:0] slot;
		logic              last;
	} item_t;

	typedef enum logic [3:0] {
		B_IDLE,
		B_DIFF,
		B_LEN_X,
		B_LEN_Y,
		B_DOT_X,
		B_DOT_Y,
		B_CLASS,
		B_DIV,
		B_OFF_X,
		B_OFF_Y,
		B_ERR,
		B_SQ_X,
		B_SQ_Y,
		B_TEST,
		B_DONE
	} bstate_t;

endpackage
`default_nettype wire

/* hw/rtl/nsch_front.sv */
// Front end: accepts target transactions, numbers the slots and marks live ones.
// Depends on nsch_pkg.
`default_nettype none
module nsch_front (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               in_valid,
	output logic                    in_ready,
	input  wire logic [23:0]        prev_x,
	input  wire logic [23:0]        prev_y,
	input  wire logic [23:0]        cur_x,
	input  wire logic [23:0]        cur_y,
	input  wire logic [15:0]        base_radius,
	input  wire logic [23:0]        target_x,
	input  wire logic [23:0]        target_y,
	input  wire logic [15:0]        target_radius,
	input  wire logic               is_entry,
	input  wire logic               last,
	output logic                    push_valid,
	input  wire logic               push_ready,
	output nsch_pkg::item_t         push_item
);

	logic [nsch_pkg::CNT_W-1:0] count_q;
	logic                       room;

	assign room       = count_q < nsch_pkg::CNT_W'(nsch_pkg::MAX_TARGETS);
	assign in_ready   = push_ready;
	assign push_valid = in_valid;

	always_comb begin
		push_item.prev_x        = prev_x;
		push_item.prev_y        = prev_y;
		push_item.cur_x         = cur_x;
		push_item.cur_y         = cur_y;
		push_item.base_radius   = base_radius;
		push_item.target_x      = target_x;
		push_item.target_y      = target_y;
		push_item.target_radius = target_radius;
		push_item.active        = is_entry && room;
		push_item.slot          = count_q[nsch_pkg::SLOT_W-1:0];
		push_item.last          = last;
	end

	// advance the slot count, saturate at the table size, clear on last
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (in_valid && push_ready) begin
			if (last) begin
				count_q <= '0;
			end else if (room) begin
				count_q <= count_q + 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/nsch_queue.sv */
// Short queue between front end and back end.
// Depends on nsch_pkg.
`default_nettype none
module nsch_queue (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire logic            push_valid,
	output logic                 push_ready,
	input  wire nsch_pkg::item_t push_item,
	output logic                 pop_valid,
	input  wire logic            pop_ready,
	output nsch_pkg::item_t      pop_item
);

	nsch_pkg::item_t             mem_q [nsch_pkg::QUEUE_DEPTH];
	logic [nsch_pkg::QPTR_W-1:0] wr_ptr_q;
	logic [nsch_pkg::QPTR_W-1:0] rd_ptr_q;
	logic [nsch_pkg::QCNT_W-1:0] cnt_q;
	logic                        push;
	logic                        pop;

	assign push_ready = cnt_q != nsch_pkg::QCNT_W'(nsch_pkg::QUEUE_DEPTH);
	assign pop_valid  = cnt_q != '0;
	assign pop_item   = mem_q[rd_ptr_q];
	assign push       = push_valid && push_ready;
	assign pop        = pop_valid && pop_ready;

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == nsch_pkg::QPTR_W'(nsch_pkg::QUEUE_DEPTH - 1)) ?
					'0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == nsch_pkg::QPTR_W'(nsch_pkg::QUEUE_DEPTH - 1)) ?
					'0 : rd_ptr_q + 1'b1;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + 1'b1;
			end else if (pop && !push) begin
				cnt_q <= cnt_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/nsch_div.sv */
// Restoring divider, one quotient bit per cycle, for the projection t.
// Requires dividend < divisor; returns floor(dividend * 2^16 / divisor).
// Depends on nsch_pkg.
`default_nettype none
module nsch_div (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	input  wire logic [nsch_pkg::LEN_W-1:0]   dividend,
	input  wire logic [nsch_pkg::LEN_W-1:0]   divisor,
	output logic                              done,
	output logic [nsch_pkg::DIV_Q_W-1:0]      quotient
);

	localparam int STEP_W = $clog2(nsch_pkg::DIV_Q_W + 1);

	logic [nsch_pkg::LEN_W:0]     rem_q;
	logic [nsch_pkg::LEN_W-1:0]   den_q;
	logic [nsch_pkg::DIV_Q_W-1:0] quo_q;
	logic [STEP_W-1:0]            step_q;
	logic                         done_q;
	logic [nsch_pkg::LEN_W:0]     rem_sh;
	logic                         fits;

	assign rem_sh   = {rem_q[nsch_pkg::LEN_W-1:0], 1'b0};
	assign fits     = rem_sh >= {1'b0, den_q};
	assign done     = done_q;
	assign quotient = quo_q;

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= {1'b0, dividend};
			den_q <= divisor;
			quo_q <= '0;
		end else if (step_q != '0) begin
			rem_q <= fits ? rem_sh - {1'b0, den_q} : rem_sh;
			quo_q <= {quo_q[nsch_pkg::DIV_Q_W-2:0], fits};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= '0;
			done_q <= 1'b0;
		end else begin
			done_q <= (step_q == STEP_W'(1)) && !start;
			if (start) begin
				step_q <= STEP_W'(nsch_pkg::DIV_Q_W);
			end else if (step_q != '0) begin
				step_q <= step_q - 1'b1;
			end
		end
	end

endmodule
`default_nettype wire

/* hw/rtl/nsch_back.sv */
// Back end: per-target geometry sequencer, nearest-hit tracking, result register.
// Depends on nsch_pkg and nsch_div.
`default_nettype none
module nsch_back (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 pop_valid,
	output logic                      pop_ready,
	input  wire nsch_pkg::item_t      pop_item,
	output logic                      out_valid,
	input  wire logic                 out_ready,
	output logic [nsch_pkg::IDX_W-1:0] hit_index,
	output logic                      hit
);

	nsch_pkg::bstate_t state_q, state_d;

	nsch_pkg::item_t                it_q;
	logic signed [24:0]             dx_q, dy_q, tpx_q, tpy_q;
	logic [nsch_pkg::LEN_W-1:0]     len_q;
	logic signed [50:0]             dot_q;
	logic [16:0]                    t_q;
	logic signed [25:0]             qx_q, qy_q;
	logic signed [26:0]             ex_q, ey_q;
	logic [53:0]                    d_q;
	logic [20:0]                    hr20_q;
	logic [34:0]                    best_q;
	logic [nsch_pkg::IDX_W-1:0]     best_slot_q;
	logic                           best_hit_q;
	logic                           out_valid_q;
	logic [nsch_pkg::IDX_W-1:0]     hit_index_q;
	logic                           hit_q;

	logic                           seg_present, dot_pos, dot_ge;
	logic                           div_start, div_done, out_load;
	logic [nsch_pkg::DIV_Q_W-1:0]   div_quo;
	logic signed [49:0]             p_dx, p_dy, p_tx, p_ty;
	logic signed [42:0]             off_x, off_y;
	logic signed [53:0]             p_ex, p_ey;
	logic [20:0]                    b20, r19;
	logic [41:0]                    lim;
	logic [43:0]                    d400;
	logic                           is_hit;

	assign seg_present = len_q > nsch_pkg::SEG_THRESHOLD;
	assign dot_pos     = dot_q > 51'sd0;
	assign dot_ge      = dot_q[49:0] >= len_q;

	assign p_dx  = dx_q * dx_q;
	assign p_dy  = dy_q * dy_q;
	assign p_tx  = tpx_q * dx_q;
	assign p_ty  = tpy_q * dy_q;
	assign off_x = dx_q * $signed({1'b0, t_q}) + 43'sd32768;
	assign off_y = dy_q * $signed({1'b0, t_q}) + 43'sd32768;
	assign p_ex  = ex_q * ex_q;
	assign p_ey  = ey_q * ey_q;
	assign b20   = 21'(it_q.base_radius) * 21'd20;
	assign r19   = 21'(it_q.target_radius) * 21'd19;
	assign lim   = 42'(hr20_q) * 42'(hr20_q);
	assign d400  = 44'(d_q[34:0]) * 44'd400;
	assign is_hit = (d_q <= nsch_pkg::D_MAX) && (d400 <= 44'(lim)) &&
		(d_q[34:0] < best_q);

	nsch_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dot_q[49:0]),
		.divisor  (len_q),
		.done     (div_done),
		.quotient (div_quo)
	);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			nsch_pkg::B_IDLE:  if (pop_valid) state_d = pop_item.active ?
				nsch_pkg::B_DIFF : nsch_pkg::B_DONE;
			nsch_pkg::B_DIFF:  state_d = nsch_pkg::B_LEN_X;
			nsch_pkg::B_LEN_X: state_d = nsch_pkg::B_LEN_Y;
			nsch_pkg::B_LEN_Y: state_d = nsch_pkg::B_DOT_X;
			nsch_pkg::B_DOT_X: state_d = nsch_pkg::B_DOT_Y;
			nsch_pkg::B_DOT_Y: state_d = nsch_pkg::B_CLASS;
			nsch_pkg::B_CLASS: begin
				if (!seg_present) state_d = nsch_pkg::B_ERR;
				else if (dot_pos && !dot_ge) state_d = nsch_pkg::B_DIV;
				else state_d = nsch_pkg::B_OFF_X;
			end
			nsch_pkg::B_DIV:   if (div_done) state_d = nsch_pkg::B_OFF_X;
			nsch_pkg::B_OFF_X: state_d = nsch_pkg::B_OFF_Y;
			nsch_pkg::B_OFF_Y: state_d = nsch_pkg::B_ERR;
			nsch_pkg::B_ERR:   state_d = nsch_pkg::B_SQ_X;
			nsch_pkg::B_SQ_X:  state_d = nsch_pkg::B_SQ_Y;
			nsch_pkg::B_SQ_Y:  state_d = nsch_pkg::B_TEST;
			nsch_pkg::B_TEST:  state_d = nsch_pkg::B_DONE;
			nsch_pkg::B_DONE:  if (!it_q.last || out_load) state_d = nsch_pkg::B_IDLE;
			default:           state_d = nsch_pkg::B_IDLE;
		endcase
	end

	always_comb begin
		pop_ready = 1'b0;
		div_start = 1'b0;
		out_load  = 1'b0;
		unique case (state_q)
			nsch_pkg::B_IDLE:  pop_ready = 1'b1;
			nsch_pkg::B_CLASS: div_start = seg_present && dot_pos && !dot_ge;
			nsch_pkg::B_DONE:  out_load = it_q.last && (!out_valid_q || out_ready);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= nsch_pkg::B_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			nsch_pkg::B_IDLE: begin
				if (pop_valid) it_q <= pop_item;
			end
			nsch_pkg::B_DIFF: begin
				dx_q   <= 25'($signed(it_q.cur_x)) - 25'($signed(it_q.prev_x));
				dy_q   <= 25'($signed(it_q.cur_y)) - 25'($signed(it_q.prev_y));
				tpx_q  <= 25'($signed(it_q.target_x)) - 25'($signed(it_q.prev_x));
				tpy_q  <= 25'($signed(it_q.target_y)) - 25'($signed(it_q.prev_y));
				hr20_q <= (r19 > b20) ? r19 : b20;
			end
			nsch_pkg::B_LEN_X: len_q <= $unsigned(p_dx);
			nsch_pkg::B_LEN_Y: len_q <= len_q + $unsigned(p_dy);
			nsch_pkg::B_DOT_X: dot_q <= 51'(p_tx);
			nsch_pkg::B_DOT_Y: dot_q <= dot_q + 51'(p_ty);
			nsch_pkg::B_CLASS: begin
				qx_q <= 26'($signed(it_q.cur_x));
				qy_q <= 26'($signed(it_q.cur_y));
				t_q  <= dot_pos ? nsch_pkg::T_ONE : '0;
			end
			nsch_pkg::B_DIV: begin
				if (div_done) t_q <= {1'b0, div_quo};
			end
			nsch_pkg::B_OFF_X: qx_q <= 26'($signed(it_q.prev_x)) + 26'(off_x >>> 16);
			nsch_pkg::B_OFF_Y: qy_q <= 26'($signed(it_q.prev_y)) + 26'(off_y >>> 16);
			nsch_pkg::B_ERR: begin
				ex_q <= 27'(qx_q) - 27'($signed(it_q.target_x));
				ey_q <= 27'(qy_q) - 27'($signed(it_q.target_y));
			end
			nsch_pkg::B_SQ_X: d_q <= $unsigned(p_ex);
			nsch_pkg::B_SQ_Y: d_q <= d_q + $unsigned(p_ey);
			default: ;
		endcase
	end

	// track the nearest hit, clear it when the list ends
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			best_q      <= '1;
			best_slot_q <= '1;
			best_hit_q  <= 1'b0;
		end else if (out_load) begin
			best_q      <= '1;
			best_slot_q <= '1;
			best_hit_q  <= 1'b0;
		end else if (state_q == nsch_pkg::B_TEST && is_hit) begin
			best_q      <= d_q[34:0];
			best_slot_q <= nsch_pkg::IDX_W'(it_q.slot);
			best_hit_q  <= 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (out_load) begin
			hit_index_q <= best_slot_q;
			hit_q       <= best_hit_q;
		end
	end

	assign out_valid = out_valid_q;
	assign hit_index = hit_index_q;
	assign hit       = hit_q;

endmodule
`default_nettype wire

/* hw/rtl/nearest_segment_circle_hit_top.sv */
// Nearest segment/circle hit: one target per input transaction, one result per list.
// A live slot steps through differences, length, dot product, class, the 16-step
// divider when the projection needs it, offset (skipped when the segment is too short
// for a projection), error, squares and test; a skipped or overflow slot goes straight
// to done. A two-entry queue lets the front accept targets while the back end works, and
// a result register holds the answer (hit index, or -1 with hit low) until it is taken.
// Depends on nsch_pkg, nsch_front, nsch_queue, nsch_back.
`default_nettype none
module nearest_segment_circle_hit_top (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [23:0] prev_x,
	input  wire logic [23:0] prev_y,
	input  wire logic [23:0] cur_x,
	input  wire logic [23:0] cur_y,
	input  wire logic [15:0] base_radius,
	input  wire logic [23:0] target_x,
	input  wire logic [23:0] target_y,
	input  wire logic [15:0] target_radius,
	input  wire logic        is_entry,
	input  wire logic        last,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [8:0]       hit_index,
	output logic             hit
);

	logic            push_valid, push_ready, pop_valid, pop_ready;
	nsch_pkg::item_t push_item, pop_item;

	nsch_front u_front (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.prev_x        (prev_x),
		.prev_y        (prev_y),
		.cur_x         (cur_x),
		.cur_y         (cur_y),
		.base_radius   (base_radius),
		.target_x      (target_x),
		.target_y      (target_y),
		.target_radius (target_radius),
		.is_entry      (is_entry),
		.last          (last),
		.push_valid    (push_valid),
		.push_ready    (push_ready),
		.push_item     (push_item)
	);

	nsch_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_item  (push_item),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_item   (pop_item)
	);

	nsch_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.pop_valid (pop_valid),
		.pop_ready (pop_ready),
		.pop_item  (pop_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.hit_index (hit_index),
		.hit       (hit)
	);

endmodule
`default_nettype wire
